@@ rtl/mma_pkg.sv @@
// Shared types, constants and helpers of the matrix multiply-accumulate engine.
package mma_pkg;

    localparam int MAX_ELEMS_DEF = 4096;
    localparam int IDX_W         = 12;
    localparam int OPND_W        = 16;
    localparam int PROD_W        = 2 * OPND_W;
    localparam int ACC_W         = 40;
    localparam int DIM_W         = 7;
    localparam int DIM_MAX       = 64;
    localparam int QUOT_W        = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int LAYOUT_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATE   = 3'd4;

    localparam logic [LAYOUT_W-1:0] LAYOUT_A_T = 2'd1;
    localparam logic [LAYOUT_W-1:0] LAYOUT_B_T = 2'd2;

    typedef enum logic [1:0] {
        ACT_LOAD_A   = 2'd0,
        ACT_LOAD_B   = 2'd1,
        ACT_LOAD_OUT = 2'd2,
        ACT_COMPUTE  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SETUP,
        S_RUN,
        S_DRAIN,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic                     a_we;
        logic                     b_we;
        logic [IDX_W-1:0]         addr;
        logic signed [OPND_W-1:0] data;
    } t_opnd_wr;

    typedef struct packed {
        logic             re;
        logic [IDX_W-1:0] a_addr;
        logic [IDX_W-1:0] b_addr;
    } t_opnd_rd;

    typedef struct packed {
        logic                    we;
        logic [IDX_W-1:0]        addr;
        logic signed [ACC_W-1:0] data;
    } t_out_wr;

    // A dimension of zero counts as one, anything above the maximum as the maximum.
    function automatic logic [DIM_W-1:0] dim_clip(input logic [DIM_W-1:0] r);
        logic [DIM_W-1:0] v;
        v = r;
        if (r == '0) begin
            v = DIM_W'(1);
        end else if (r > DIM_W'(DIM_MAX)) begin
            v = DIM_W'(DIM_MAX);
        end
        return v;
    endfunction

endpackage

@@ rtl/mma_opnd_fetch.sv @@
// Operand stores for A and B with a registered dual read for the inner-product walk.
module mma_opnd_fetch #(
    parameter int MAX_ELEMS = mma_pkg::MAX_ELEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mma_pkg::t_opnd_wr                i_wr,
    input  mma_pkg::t_opnd_rd                i_rd,
    output logic                             o_valid,
    output logic signed [mma_pkg::OPND_W-1:0] o_a,
    output logic signed [mma_pkg::OPND_W-1:0] o_b
);

    localparam int AW = $clog2(MAX_ELEMS);

    logic signed [mma_pkg::OPND_W-1:0] r_a_mem [MAX_ELEMS];
    logic signed [mma_pkg::OPND_W-1:0] r_b_mem [MAX_ELEMS];
    logic signed [mma_pkg::OPND_W-1:0] r_a_rdata;
    logic signed [mma_pkg::OPND_W-1:0] r_b_rdata;
    logic                              r_a_oob;
    logic                              r_b_oob;
    logic                              r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.a_we) begin
            r_a_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (i_wr.b_we) begin
            r_b_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (i_rd.re) begin
            r_a_rdata <= r_a_mem[AW'(i_rd.a_addr)];
            r_b_rdata <= r_b_mem[AW'(i_rd.b_addr)];
            r_a_oob   <= 32'(i_rd.a_addr) >= MAX_ELEMS;
            r_b_oob   <= 32'(i_rd.b_addr) >= MAX_ELEMS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_rd.re;
        end
    end

    // An address beyond the store reads as zero.
    assign o_valid = r_valid;
    assign o_a     = r_a_oob ? '0 : r_a_rdata;
    assign o_b     = r_b_oob ? '0 : r_b_rdata;

endmodule

@@ rtl/mma_mac.sv @@
// Registered multiplier followed by a saturating accumulator with a sticky clip flag.
module mma_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_init,
    input  logic signed [mma_pkg::ACC_W-1:0]  i_init_value,
    input  logic                              i_valid,
    input  logic signed [mma_pkg::OPND_W-1:0] i_a,
    input  logic signed [mma_pkg::OPND_W-1:0] i_b,
    output logic signed [mma_pkg::ACC_W-1:0]  o_acc,
    output logic                              o_sat,
    output logic                              o_pending
);

    localparam int SUM_W = mma_pkg::ACC_W + 1;

    logic signed [mma_pkg::PROD_W-1:0] r_prod;
    logic                              r_prod_valid;
    logic signed [mma_pkg::ACC_W-1:0]  r_acc;
    logic                              r_sat;
    logic [SUM_W-1:0]                  w_sum;
    logic                              w_ovf;
    logic [mma_pkg::ACC_W-1:0]         w_clip;

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_prod <= i_a * i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else begin
            r_prod_valid <= i_valid;
        end
    end

    // One guard bit shows whether the exact sum left the accumulator range.
    assign w_sum  = {r_acc[mma_pkg::ACC_W-1], r_acc} + SUM_W'(r_prod);
    assign w_ovf  = w_sum[SUM_W-1] != w_sum[SUM_W-2];
    assign w_clip = w_sum[SUM_W-1] ? {1'b1, {(mma_pkg::ACC_W-1){1'b0}}}
                                   : {1'b0, {(mma_pkg::ACC_W-1){1'b1}}};

    always_ff @(posedge i_clk) begin
        if (i_init) begin
            r_acc <= i_init_value;
            r_sat <= 1'b0;
        end else if (r_prod_valid) begin
            r_acc <= w_ovf ? w_clip : w_sum[mma_pkg::ACC_W-1:0];
            if (w_ovf) begin
                r_sat <= 1'b1;
            end
        end
    end

    assign o_acc     = r_acc;
    assign o_sat     = r_sat;
    assign o_pending = r_prod_valid;

    a_sat_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_init && r_sat) |=> r_sat)
        else $error("clip flag dropped in the middle of a sum");

endmodule

@@ rtl/mma_out_store.sv @@
// Output value store with a clearing sweep after reset.
module mma_out_store #(
    parameter int MAX_ELEMS = mma_pkg::MAX_ELEMS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mma_pkg::t_out_wr                 i_wr,
    input  logic                             i_re,
    input  logic [mma_pkg::IDX_W-1:0]        i_raddr,
    output logic signed [mma_pkg::ACC_W-1:0] o_rdata,
    output logic                             o_clearing
);

    localparam int AW = $clog2(MAX_ELEMS);

    logic signed [mma_pkg::ACC_W-1:0] r_mem [MAX_ELEMS];
    logic signed [mma_pkg::ACC_W-1:0] r_rdata;
    logic [AW-1:0]                    r_clr_addr;
    logic                             r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(MAX_ELEMS - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr.we) begin
            r_mem[AW'(i_wr.addr)] <= i_wr.data;
        end
        if (i_re) begin
            r_rdata <= r_mem[AW'(i_raddr)];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

    a_no_write_in_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !i_wr.we)
        else $error("output store written during the clearing sweep");

endmodule

@@ rtl/matrix_multiply_accumulate.sv @@
// Top level of the matrix multiply-accumulate engine: control, address walk and result register.
//
// Channel      Direction  Handshake                 Payload
// request      in         start && !busy            i_action, i_index, i_operand, i_prior
// result       out        o_result_valid (1 cycle)  o_out_value, o_out_index, o_saturated,
//                                                   o_index_error
// config       in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// Load requests are written on acceptance and leave busy low. A compute request for a valid
// index runs through six divider steps that split the index into row and column, a setup
// state, then one operand pair per cycle from the A and B store ports, then the drain of the
// multiplier and accumulator registers and the write-back state before the result strobe.
// An out-of-range index gives its result in the cycle after acceptance.
// After reset the output store is swept to zero with busy high; configuration writes are
// taken throughout. Results cannot be held off.
module matrix_multiply_accumulate #(
    parameter int MAX_ELEMS = mma_pkg::MAX_ELEMS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           i_action,
    input  logic [mma_pkg::IDX_W-1:0]            i_index,
    input  logic signed [mma_pkg::OPND_W-1:0]    i_operand,
    input  logic signed [mma_pkg::ACC_W-1:0]     i_prior,
    input  logic                                 i_cfg_we,
    input  logic [mma_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mma_pkg::DIM_W-1:0]            i_cfg_data,
    output logic                                 o_result_valid,
    output logic signed [mma_pkg::ACC_W-1:0]     o_out_value,
    output logic [mma_pkg::IDX_W-1:0]            o_out_index,
    output logic                                 o_saturated,
    output logic                                 o_index_error
);

    localparam int IDX_W  = mma_pkg::IDX_W;
    localparam int DIM_W  = mma_pkg::DIM_W;
    localparam int QUOT_W = mma_pkg::QUOT_W;
    localparam int MP_W   = 2 * DIM_W;
    localparam int STEP_W = $clog2(QUOT_W);

    // Configuration registers.
    logic [DIM_W-1:0]             r_row_count;
    logic [DIM_W-1:0]             r_inner_length;
    logic [DIM_W-1:0]             r_col_count;
    logic [mma_pkg::LAYOUT_W-1:0] r_layout_mode;
    logic                         r_accumulate;

    mma_pkg::t_state  r_state;
    mma_pkg::t_state  n_state;
    mma_pkg::t_action w_action;

    logic [DIM_W-1:0]  w_m;
    logic [DIM_W-1:0]  w_n;
    logic [DIM_W-1:0]  w_p;
    logic [MP_W-1:0]   w_mp;
    logic              w_accept;
    logic              w_in_range;
    logic              w_idx_err;
    logic              w_start_compute;
    logic              w_err_result;
    logic              w_last;
    logic              w_clearing;
    logic [IDX_W-1:0]  w_row_n;
    logic [IDX_W-1:0]  w_col_n;

    // Compute datapath registers.
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_rem;
    logic [IDX_W-1:0]  r_div;
    logic [QUOT_W-1:0] r_quot;
    logic [STEP_W-1:0] r_step;
    logic [IDX_W-1:0]  r_a_addr;
    logic [IDX_W-1:0]  r_b_addr;
    logic [DIM_W-1:0]  r_a_step;
    logic [DIM_W-1:0]  r_b_step;
    logic [QUOT_W-1:0] r_k;

    // Result register.
    logic                             r_result_valid;
    logic signed [mma_pkg::ACC_W-1:0] r_out_value;
    logic [IDX_W-1:0]                 r_out_index;
    logic                             r_saturated;
    logic                             r_index_error;

    mma_pkg::t_opnd_wr w_opnd_wr;
    mma_pkg::t_opnd_rd w_opnd_rd;
    mma_pkg::t_out_wr  w_out_wr;

    logic                              w_rd_valid;
    logic signed [mma_pkg::OPND_W-1:0] w_a;
    logic signed [mma_pkg::OPND_W-1:0] w_b;
    logic signed [mma_pkg::ACC_W-1:0]  w_out_rdata;
    logic signed [mma_pkg::ACC_W-1:0]  w_init_value;
    logic                              w_mac_init;
    logic signed [mma_pkg::ACC_W-1:0]  w_acc;
    logic                              w_sat;
    logic                              w_mac_pending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= DIM_W'(1);
            r_inner_length <= DIM_W'(1);
            r_col_count    <= DIM_W'(1);
            r_layout_mode  <= '0;
            r_accumulate   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mma_pkg::CFG_ROW_COUNT:    r_row_count    <= i_cfg_data;
                mma_pkg::CFG_INNER_LENGTH: r_inner_length <= i_cfg_data;
                mma_pkg::CFG_COL_COUNT:    r_col_count    <= i_cfg_data;
                mma_pkg::CFG_LAYOUT_MODE:  r_layout_mode  <= i_cfg_data[mma_pkg::LAYOUT_W-1:0];
                mma_pkg::CFG_ACCUMULATE:   r_accumulate   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign w_m  = mma_pkg::dim_clip(r_row_count);
    assign w_n  = mma_pkg::dim_clip(r_inner_length);
    assign w_p  = mma_pkg::dim_clip(r_col_count);
    assign w_mp = MP_W'(w_m) * MP_W'(w_p);

    assign busy            = (r_state != mma_pkg::S_IDLE) || w_clearing;
    assign w_accept        = start && !busy;
    assign w_action        = mma_pkg::t_action'(i_action);
    assign w_in_range      = 32'(i_index) < MAX_ELEMS;
    assign w_idx_err       = (MP_W'(i_index) >= w_mp) || !w_in_range;
    assign w_start_compute = w_accept && (w_action == mma_pkg::ACT_COMPUTE) && !w_idx_err;
    assign w_err_result    = w_accept && (w_action == mma_pkg::ACT_COMPUTE) && w_idx_err;
    assign w_last          = r_k == QUOT_W'(w_n - 1'b1);

    // Row times N and column times N for the start addresses of the walk.
    assign w_row_n = IDX_W'(r_quot) * IDX_W'(w_n);
    assign w_col_n = IDX_W'(r_rem[QUOT_W-1:0]) * IDX_W'(w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;

        w_opnd_wr.a_we = w_accept && (w_action == mma_pkg::ACT_LOAD_A) && w_in_range;
        w_opnd_wr.b_we = w_accept && (w_action == mma_pkg::ACT_LOAD_B) && w_in_range;
        w_opnd_wr.addr = i_index;
        w_opnd_wr.data = i_operand;

        w_opnd_rd.re     = 1'b0;
        w_opnd_rd.a_addr = r_a_addr;
        w_opnd_rd.b_addr = r_b_addr;

        w_out_wr.we   = w_accept && (w_action == mma_pkg::ACT_LOAD_OUT) && w_in_range;
        w_out_wr.addr = i_index;
        w_out_wr.data = i_prior;

        unique case (r_state)
            mma_pkg::S_IDLE: begin
                if (w_start_compute) begin
                    n_state = mma_pkg::S_DIV;
                end
            end
            mma_pkg::S_DIV: begin
                if (r_step == '0) begin
                    n_state = mma_pkg::S_SETUP;
                end
            end
            mma_pkg::S_SETUP: begin
                n_state = mma_pkg::S_RUN;
            end
            mma_pkg::S_RUN: begin
                w_opnd_rd.re = 1'b1;
                if (w_last) begin
                    n_state = mma_pkg::S_DRAIN;
                end
            end
            mma_pkg::S_DRAIN: begin
                if (!w_rd_valid && !w_mac_pending) begin
                    n_state = mma_pkg::S_WRITE;
                end
            end
            mma_pkg::S_WRITE: begin
                w_out_wr.we   = 1'b1;
                w_out_wr.addr = r_idx;
                w_out_wr.data = w_acc;
                n_state       = mma_pkg::S_IDLE;
            end
        endcase
    end

    // Restoring division of the index by P, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (w_start_compute) begin
            r_idx  <= i_index;
            r_rem  <= i_index;
            r_div  <= IDX_W'(w_p) << (QUOT_W - 1);
            r_quot <= '0;
            r_step <= STEP_W'(QUOT_W - 1);
        end
        if (r_state == mma_pkg::S_DIV) begin
            if (r_rem >= r_div) begin
                r_rem  <= r_rem - r_div;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
            r_div  <= r_div >> 1;
            r_step <= r_step - 1'b1;
        end
        if (r_state == mma_pkg::S_SETUP) begin
            r_k <= '0;
            if (r_layout_mode == mma_pkg::LAYOUT_A_T) begin
                r_a_addr <= IDX_W'(r_quot);
                r_a_step <= w_m;
            end else begin
                r_a_addr <= w_row_n;
                r_a_step <= DIM_W'(1);
            end
            if (r_layout_mode == mma_pkg::LAYOUT_B_T) begin
                r_b_addr <= w_col_n;
                r_b_step <= DIM_W'(1);
            end else begin
                r_b_addr <= IDX_W'(r_rem[QUOT_W-1:0]);
                r_b_step <= w_p;
            end
        end
        if (r_state == mma_pkg::S_RUN) begin
            r_a_addr <= r_a_addr + IDX_W'(r_a_step);
            r_b_addr <= r_b_addr + IDX_W'(r_b_step);
            r_k      <= r_k + 1'b1;
        end
    end

    // The stored output read in setup seeds the sum on the first walk cycle when accumulating.
    assign w_mac_init   = (r_state == mma_pkg::S_RUN) && (r_k == '0);
    assign w_init_value = r_accumulate ? w_out_rdata : '0;

    mma_opnd_fetch #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_opnd_fetch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_opnd_wr),
        .i_rd    (w_opnd_rd),
        .o_valid (w_rd_valid),
        .o_a     (w_a),
        .o_b     (w_b)
    );

    mma_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_init       (w_mac_init),
        .i_init_value (w_init_value),
        .i_valid      (w_rd_valid),
        .i_a          (w_a),
        .i_b          (w_b),
        .o_acc        (w_acc),
        .o_sat        (w_sat),
        .o_pending    (w_mac_pending)
    );

    mma_out_store #(
        .MAX_ELEMS (MAX_ELEMS)
    ) u_out_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (w_out_wr),
        .i_re       (r_state == mma_pkg::S_SETUP),
        .i_raddr    (r_idx),
        .o_rdata    (w_out_rdata),
        .o_clearing (w_clearing)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_err_result || (r_state == mma_pkg::S_WRITE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_err_result) begin
            r_out_value   <= '0;
            r_out_index   <= i_index;
            r_saturated   <= 1'b0;
            r_index_error <= 1'b1;
        end else if (r_state == mma_pkg::S_WRITE) begin
            r_out_value   <= w_acc;
            r_out_index   <= r_idx;
            r_saturated   <= w_sat;
            r_index_error <= 1'b0;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_out_value    = r_out_value;
    assign o_out_index    = r_out_index;
    assign o_saturated    = r_saturated;
    assign o_index_error  = r_index_error;

    a_idle_pipe_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::S_IDLE) |-> (!w_rd_valid && !w_mac_pending))
        else $error("operand pipeline still busy while idle");

    a_col_below_p : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::S_SETUP) |-> (r_rem < IDX_W'(w_p)))
        else $error("divider remainder not below the column count");

    a_err_result_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_result_valid && r_index_error) |-> ((r_out_value == '0) && !r_saturated))
        else $error("index error result carries a value or a clip flag");

    a_write_back_once : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mma_pkg::S_WRITE) |=> (r_result_valid && !r_index_error))
        else $error("write-back not followed by its result");

endmodule

@@ dv/tb_matrix_multiply_accumulate.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the matrix multiply-accumulate engine, built around a scoreboard class.
module tb_matrix_multiply_accumulate;
    import mma_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned ITEM_TARGET   = 1250;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES   = 100;
    localparam int unsigned MAX_GAP       = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 3'd7;
    localparam logic [LAYOUT_W-1:0]  LAYOUT_PLAIN = 2'd0;
    localparam logic [LAYOUT_W-1:0]  LAYOUT_SPARE = 2'd3;

    localparam logic signed [ACC_W-1:0]  ACC_HI  = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  ACC_LO  = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OPND_W-1:0] OPND_HI = {1'b0, {(OPND_W-1){1'b1}}};
    localparam logic signed [OPND_W-1:0] OPND_LO = {1'b1, {(OPND_W-1){1'b0}}};

    typedef struct {
        logic signed [ACC_W-1:0] value;
        logic [IDX_W-1:0]        index;
        logic                    sat;
        logic                    err;
    } t_element;

    class product_scoreboard;
        logic signed [OPND_W-1:0] a_mem   [MAX_ELEMS_DEF];
        logic signed [OPND_W-1:0] b_mem   [MAX_ELEMS_DEF];
        logic signed [ACC_W-1:0]  out_mem [MAX_ELEMS_DEF];
        bit                       a_loaded[MAX_ELEMS_DEF];
        bit                       b_loaded[MAX_ELEMS_DEF];
        logic [DIM_W-1:0]         rows_reg;
        logic [DIM_W-1:0]         inner_reg;
        logic [DIM_W-1:0]         cols_reg;
        logic [LAYOUT_W-1:0]      layout_reg;
        logic                     acc_reg;
        t_element                 expected_elements[$];
        int unsigned              fail_count;

        function new();
            foreach (out_mem[i]) begin
                a_mem[i]    = '0;
                b_mem[i]    = '0;
                out_mem[i]  = '0;
                a_loaded[i] = 1'b0;
                b_loaded[i] = 1'b0;
            end
            rows_reg   = 7'd1;
            inner_reg  = 7'd1;
            cols_reg   = 7'd1;
            layout_reg = LAYOUT_PLAIN;
            acc_reg    = 1'b0;
            fail_count = 0;
        endfunction

        function int unsigned eff_dim(logic [DIM_W-1:0] r);
            if (r == '0) return 1;
            if (r > DIM_MAX) return DIM_MAX;
            return r;
        endfunction

        function int unsigned rows();
            return eff_dim(rows_reg);
        endfunction

        function int unsigned inner();
            return eff_dim(inner_reg);
        endfunction

        function int unsigned cols();
            return eff_dim(cols_reg);
        endfunction

        function int unsigned a_addr(int unsigned row, int unsigned k);
            if (layout_reg == LAYOUT_A_T) return k * rows() + row;
            return row * inner() + k;
        endfunction

        function int unsigned b_addr(int unsigned col, int unsigned k);
            if (layout_reg == LAYOUT_B_T) return col * inner() + k;
            return k * cols() + col;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            case (idx)
                CFG_ROW_COUNT:    rows_reg   = data;
                CFG_INNER_LENGTH: inner_reg  = data;
                CFG_COL_COUNT:    cols_reg   = data;
                CFG_LAYOUT_MODE:  layout_reg = data[LAYOUT_W-1:0];
                CFG_ACCUMULATE:   acc_reg    = data[0];
                default: ;
            endcase
        endfunction

        // Forms one output element and writes it back, as the block does.
        function t_element predict_element(logic [IDX_W-1:0] idx);
            t_element    e;
            int unsigned m, n, p, row, col, k;
            longint      acc, prod, hi, lo;
            m       = rows();
            n       = inner();
            p       = cols();
            e.index = idx;
            e.value = '0;
            e.sat   = 1'b0;
            e.err   = 1'b0;
            if (idx >= m * p) begin
                e.err = 1'b1;
                return e;
            end
            row = idx / p;
            col = idx % p;
            hi  = ACC_HI;
            lo  = ACC_LO;
            acc = acc_reg ? longint'(out_mem[idx]) : 0;
            for (k = 0; k < n; k++) begin
                prod = longint'(a_mem[a_addr(row, k)]) * longint'(b_mem[b_addr(col, k)]);
                if (prod > 0 && acc > hi - prod) begin
                    acc   = hi;
                    e.sat = 1'b1;
                end else if (prod < 0 && acc < lo - prod) begin
                    acc   = lo;
                    e.sat = 1'b1;
                end else begin
                    acc += prod;
                end
            end
            out_mem[idx] = acc[ACC_W-1:0];
            e.value      = acc[ACC_W-1:0];
            return e;
        endfunction

        function void note_request(t_action act, logic [IDX_W-1:0] idx,
                                   logic signed [OPND_W-1:0] opnd,
                                   logic signed [ACC_W-1:0] pri);
            case (act)
                ACT_LOAD_A: begin
                    a_mem[idx]    = opnd;
                    a_loaded[idx] = 1'b1;
                end
                ACT_LOAD_B: begin
                    b_mem[idx]    = opnd;
                    b_loaded[idx] = 1'b1;
                end
                ACT_LOAD_OUT: out_mem[idx] = pri;
                default: expected_elements.push_back(predict_element(idx));
            endcase
        endfunction

        function void check_result(logic signed [ACC_W-1:0] value, logic [IDX_W-1:0] index,
                                   logic sat, logic err);
            t_element e;
            if (expected_elements.size() == 0) begin
                $error("result for index %0d arrived with no request waiting", index);
                fail_count++;
                return;
            end
            e = expected_elements.pop_front();
            if (value !== e.value) begin
                $error("out_value: expected %0d, actual %0d", e.value, value);
                fail_count++;
            end
            if (index !== e.index) begin
                $error("out_index: expected %0d, actual %0d", e.index, index);
                fail_count++;
            end
            if (sat !== e.sat) begin
                $error("saturated: expected %0b, actual %0b", e.sat, sat);
                fail_count++;
            end
            if (err !== e.err) begin
                $error("index_error: expected %0b, actual %0b", e.err, err);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_elements.size();
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    start       = 1'b0;
    logic                    busy;
    logic [1:0]              i_action    = ACT_LOAD_A;
    logic [IDX_W-1:0]        i_index     = '0;
    logic signed [OPND_W-1:0] i_operand  = '0;
    logic signed [ACC_W-1:0] i_prior     = '0;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_ROW_COUNT;
    logic [DIM_W-1:0]        i_cfg_data  = '0;
    logic                    o_result_valid;
    logic signed [ACC_W-1:0] o_out_value;
    logic [IDX_W-1:0]        o_out_index;
    logic                    o_saturated;
    logic                    o_index_error;

    product_scoreboard sb;
    int unsigned       requests_sent = 0;
    int unsigned       cycle_count   = 0;
    bit                steady        = 1'b0;

    matrix_multiply_accumulate dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_index        (i_index),
        .i_operand      (i_operand),
        .i_prior        (i_prior),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_out_value    (o_out_value),
        .o_out_index    (o_out_index),
        .o_saturated    (o_saturated),
        .o_index_error  (o_index_error)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result(o_out_value, o_out_index, o_saturated, o_index_error);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_matrix_multiply_accumulate NOT OK");
            $finish;
        end
    end

    function automatic logic signed [OPND_W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0:       return OPND_HI;
            1:       return OPND_LO;
            2:       return '0;
            default: return OPND_W'($urandom);
        endcase
    endfunction

    function automatic logic signed [ACC_W-1:0] rand_prior();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0:       return ACC_HI;
            1:       return ACC_LO;
            2:       return ACC_HI - raw[15:0];
            3:       return ACC_LO + raw[15:0];
            default: return raw[ACC_W-1:0];
        endcase
    endfunction

    // Mostly inside the current matrix, now and then anywhere in the store.
    function automatic logic [IDX_W-1:0] pick_index(int unsigned limit);
        if ($urandom_range(0, 3) == 0) return IDX_W'($urandom_range(0, MAX_ELEMS_DEF - 1));
        return IDX_W'($urandom_range(0, limit - 1));
    endfunction

    task automatic pause_sender();
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_request(t_action act, logic [IDX_W-1:0] idx,
                                logic signed [OPND_W-1:0] opnd, logic signed [ACC_W-1:0] pri);
        start     <= 1'b1;
        i_action  <= act;
        i_index   <= idx;
        i_operand <= opnd;
        i_prior   <= pri;
        do @(posedge i_clk); while (busy);
        sb.note_request(act, idx, opnd, pri);
        requests_sent++;
        pause_sender();
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (busy);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(logic [DIM_W-1:0] m, logic [DIM_W-1:0] n, logic [DIM_W-1:0] p,
                                 logic [LAYOUT_W-1:0] lay, logic acc);
        wait_drained();
        write_reg(CFG_ROW_COUNT, m);
        write_reg(CFG_INNER_LENGTH, n);
        write_reg(CFG_COL_COUNT, p);
        write_reg(CFG_LAYOUT_MODE, DIM_W'(lay));
        write_reg(CFG_ACCUMULATE, DIM_W'(acc));
        i_cfg_we <= 1'b0;
    endtask

    // Loads every A and B entry that the element will read and that holds nothing yet.
    task automatic ensure_operands(logic [IDX_W-1:0] idx);
        int unsigned m, n, p, row, col, k, aa, ba;
        m = sb.rows();
        n = sb.inner();
        p = sb.cols();
        if (idx >= m * p) return;
        row = idx / p;
        col = idx % p;
        for (k = 0; k < n; k++) begin
            aa = sb.a_addr(row, k);
            if (!sb.a_loaded[aa]) send_request(ACT_LOAD_A, IDX_W'(aa), rand_operand(), rand_prior());
            ba = sb.b_addr(col, k);
            if (!sb.b_loaded[ba]) send_request(ACT_LOAD_B, IDX_W'(ba), rand_operand(), rand_prior());
        end
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned      i, sel, m, n, p;
        logic [IDX_W-1:0] idx;
        m      = sb.rows();
        n      = sb.inner();
        p      = sb.cols();
        steady = ($urandom_range(0, 3) == 0);
        for (i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom_range(0, MAX_ELEMS_DEF - 1));
                else idx = IDX_W'($urandom_range(0, m * p - 1));
                ensure_operands(idx);
                send_request(ACT_COMPUTE, idx, rand_operand(), rand_prior());
            end else if (sel < 70) begin
                send_request(ACT_LOAD_A, pick_index(m * n), rand_operand(), rand_prior());
            end else if (sel < 90) begin
                send_request(ACT_LOAD_B, pick_index(n * p), rand_operand(), rand_prior());
            end else begin
                send_request(ACT_LOAD_OUT, pick_index(m * p), rand_operand(), rand_prior());
            end
            if ($urandom_range(0, 59) == 0) wait_drained();
        end
        steady = 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // A write to an index with no register behind it must change nothing.
        write_reg(CFG_UNUSED, '1);
        i_cfg_we <= 1'b0;

        // Single-element products at the operand extremes.
        send_request(ACT_LOAD_A, '0, OPND_HI, '0);
        send_request(ACT_LOAD_B, '0, OPND_HI, '0);
        send_request(ACT_COMPUTE, '0, '0, '0);
        send_request(ACT_LOAD_A, '0, OPND_LO, '0);
        send_request(ACT_LOAD_B, '0, OPND_LO, '0);
        send_request(ACT_COMPUTE, '0, OPND_HI, ACC_HI);
        send_request(ACT_LOAD_B, '0, OPND_HI, '0);
        send_request(ACT_COMPUTE, '0, OPND_LO, ACC_LO);
        // Elements outside the one by one output.
        send_request(ACT_COMPUTE, IDX_W'(1), '0, '0);
        send_request(ACT_COMPUTE, '1, '1, '1);
        // A stored value at the top of the range pushed over it, then the bottom.
        send_request(ACT_LOAD_OUT, '0, '0, ACC_HI);
        send_request(ACT_LOAD_A, '0, OPND_HI, '0);
        apply_setting(7'd1, 7'd1, 7'd1, LAYOUT_PLAIN, 1'b1);
        send_request(ACT_COMPUTE, '0, '0, '0);
        send_request(ACT_LOAD_OUT, '0, '0, ACC_LO);
        send_request(ACT_LOAD_A, '0, OPND_LO, '0);
        send_request(ACT_COMPUTE, '0, '0, '0);
        send_request(ACT_COMPUTE, '0, '0, '0);
        // Loads at the last entry of each store.
        send_request(ACT_LOAD_A, '1, OPND_LO, '0);
        send_request(ACT_LOAD_B, '1, OPND_HI, '0);
        send_request(ACT_LOAD_OUT, '1, '0, {(ACC_W/2){2'b10}});

        apply_setting(7'd4, 7'd3, 7'd5, LAYOUT_PLAIN, 1'b0);
        random_phase(120);
        apply_setting(7'd3, 7'd4, 7'd2, LAYOUT_A_T, 1'b1);
        random_phase(120);
        apply_setting(7'd5, 7'd2, 7'd4, LAYOUT_B_T, 1'b0);
        random_phase(120);
        apply_setting(7'd2, 7'd6, 7'd3, LAYOUT_SPARE, 1'b1);
        random_phase(80);
        // Zero dimensions act as one.
        apply_setting(7'd0, 7'd0, 7'd0, LAYOUT_PLAIN, 1'b1);
        random_phase(40);
        apply_setting(7'd64, 7'd1, 7'd64, LAYOUT_B_T, 1'b1);
        random_phase(40);
        apply_setting(7'd1, 7'd64, 7'd1, LAYOUT_A_T, 1'b0);
        random_phase(40);
        // Full-size products pull in many operand loads, so they stay short.
        apply_setting(7'd64, 7'd64, 7'd64, LAYOUT_PLAIN, 1'b0);
        random_phase(4);
        // Dimensions above the maximum act as the maximum.
        apply_setting(7'd100, 7'd127, 7'd64, LAYOUT_A_T, 1'b1);
        random_phase(4);
        while (requests_sent < ITEM_TARGET) begin
            apply_setting(DIM_W'($urandom_range(1, 8)), DIM_W'($urandom_range(1, 8)),
                          DIM_W'($urandom_range(1, 8)), LAYOUT_W'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)));
            random_phase(60);
        end

        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("tb_matrix_multiply_accumulate OK");
        end else begin
            $display("tb_matrix_multiply_accumulate NOT OK");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mma_pkg.sv
rtl/mma_opnd_fetch.sv
rtl/mma_mac.sv
rtl/mma_out_store.sv
rtl/matrix_multiply_accumulate.sv
dv/tb_matrix_multiply_accumulate.sv
